[src/lookahead_peak_limiter_macros.svh]
// assertion helpers for the peak limiter checker
// both expect clk and rst_n in the scope of use
`ifndef LOOKAHEAD_PEAK_LIMITER_MACROS_SVH
`define LOOKAHEAD_PEAK_LIMITER_MACROS_SVH

// same-cycle implication
`define LPL_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lookahead_peak_limiter: check failed");

// next-cycle implication
`define LPL_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lookahead_peak_limiter: check failed");

`endif

[src/lpl_pkg.sv]
`default_nettype none

package lpl_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int TAP_COUNT     = 8;
    localparam int MAX_LOOKAHEAD = 1024;

    localparam int RING_AW    = $clog2(MAX_LOOKAHEAD);
    localparam int LEN_W      = RING_AW + 1;
    localparam int CEIL_W     = 24;
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 17;
    localparam int FRAC_BITS  = 16;
    localparam int TAP_IW     = $clog2(TAP_COUNT);
    localparam int MAG_W      = SAMPLE_BITS + 1;
    localparam int MAC_A_W    = SAMPLE_BITS + 1;
    localparam int MAC_B_W    = GAIN_W + 1;
    localparam int PROD_W     = MAC_A_W + MAC_B_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int QUO_W      = 16;
    localparam int DIV_CNT_W  = $clog2(QUO_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int HOLD_W     = 24;

    localparam logic [GAIN_W-1:0] UNITY      = GAIN_W'(65536);
    localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [MAG_W-1:0]  SMAX       = MAG_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [HOLD_W-1:0] PEAK_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CEILING   = 2'd0,
        REG_RELEASE   = 2'd1,
        REG_LOOKAHEAD = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIR,
        ST_PEAK,
        ST_DIV,
        ST_REL1,
        ST_REL2,
        ST_RSUM,
        ST_GAIN,
        ST_FINISH
    } lpl_state_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_start;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [GAIN_W-1:0]             gain_now;
        logic [HOLD_W-1:0]             peak_held;
        logic [GAIN_W-1:0]             reduction_held;
    } out_item_t;

    typedef struct packed {
        logic en;
        logic clr;
    } mac_ctrl_t;

    // hann-windowed sinc, cutoff pi/4, sums to unity
    function automatic logic [COEF_W-1:0] tap_coef(input logic [TAP_IW-1:0] idx);
        logic [COEF_W-1:0] c;
        unique case (idx)
            3'd1:    c = COEF_W'(1943);
            3'd2:    c = COEF_W'(10512);
            3'd3:    c = COEF_W'(20313);
            3'd4:    c = COEF_W'(20313);
            3'd5:    c = COEF_W'(10512);
            3'd6:    c = COEF_W'(1943);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[src/lpl_ram.sv]
`default_nettype none

module lpl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/lpl_mac.sv]
`default_nettype none

module lpl_mac (
    input  wire logic                                   clk,
    input  wire lpl_pkg::mac_ctrl_t                     ctrl,
    input  wire logic signed [lpl_pkg::MAC_A_W-1:0]     a,
    input  wire logic signed [lpl_pkg::MAC_B_W-1:0]     b,
    output logic signed      [lpl_pkg::ACC_W-1:0]       acc
);

    logic signed [lpl_pkg::PROD_W-1:0] prod;
    logic signed [lpl_pkg::ACC_W-1:0]  acc_reg;
    logic signed [lpl_pkg::ACC_W-1:0]  acc_next;

    assign prod = a * b;

    always_comb
    begin
        acc_next = (ctrl.clr ? '0 : acc_reg) + lpl_pkg::ACC_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[src/lpl_div.sv]
`default_nettype none

module lpl_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lpl_pkg::MAG_W-1:0]     dividend_hi,
    input  wire logic [lpl_pkg::MAG_W-1:0]     divisor,
    output logic                               done,
    output logic      [lpl_pkg::QUO_W-1:0]     quotient
);

    // restoring divide of dividend_hi * 2^QUO_W, valid while dividend_hi < divisor
    logic                              busy_reg;
    logic                              done_reg;
    logic [lpl_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [lpl_pkg::MAG_W-1:0]         rem_reg;
    logic [lpl_pkg::MAG_W-1:0]         div_reg;
    logic [lpl_pkg::QUO_W-1:0]         quo_reg;
    logic [lpl_pkg::MAG_W:0]           rem_sh;
    logic                              ge;
    logic [lpl_pkg::MAG_W-1:0]         rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, 1'b0};
        ge       = rem_sh >= {1'b0, div_reg};
        rem_next = ge ? lpl_pkg::MAG_W'(rem_sh - {1'b0, div_reg})
                      : rem_sh[lpl_pkg::MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lpl_pkg::DIV_CNT_W'(lpl_pkg::QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend_hi;
            div_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[lpl_pkg::QUO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[src/lookahead_peak_limiter.sv]
// lookahead peak limiter
// in_valid/in_stall carry one item: a signed sample and a block_start flag.
// out_valid/out_stall carry one result per item: the gained sample delayed by the
// lookahead ring, the smoothed gain, and the peak and reduction holds.
// cfg_en/cfg_index/cfg_data write ceiling, release coefficient and lookahead
// length; write only while no item is in flight.
// one shared multiply-accumulate runs the 8 fir taps and the release and gain
// products; a radix-2 divider forms ceiling/peak, one quotient bit a cycle.
// an item steps through fir and peak, the divider only when the peak is above
// the ceiling, release unless an instant attack skips it, then gain and finish;
// in_stall is high meanwhile, so the next item is accepted only after finish.
// after reset a clearing pass zeroes the 1024-entry ring with in_stall high;
// configuration writes are taken during it.
// the result sits in an output register: the next item is accepted while it
// waits, and a stalled receiver holds the block in its last step until the
// result is taken.
`default_nettype none

module lookahead_peak_limiter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire lpl_pkg::in_item_t                 in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output lpl_pkg::out_item_t                     out_data,
    input  wire logic                              cfg_en,
    input  wire logic [lpl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lpl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SB = lpl_pkg::SAMPLE_BITS;
    localparam int FB = lpl_pkg::FRAC_BITS;

    lpl_pkg::lpl_state_t state_reg, state_next;

    logic [lpl_pkg::CEIL_W-1:0]      ceil_reg;
    logic [lpl_pkg::COEF_W-1:0]      rel_reg;
    logic [lpl_pkg::LEN_W-1:0]       len_reg;
    logic signed [SB-1:0]            tap_reg [lpl_pkg::TAP_COUNT];
    logic [lpl_pkg::RING_AW-1:0]     ring_pos_reg;
    logic [lpl_pkg::RING_AW-1:0]     pos_reg;
    logic [lpl_pkg::RING_AW-1:0]     clr_cnt_reg;
    logic [lpl_pkg::TAP_IW-1:0]      k_reg;
    logic signed [SB-1:0]            sample_reg;
    logic [lpl_pkg::GAIN_W-1:0]      gain_reg;
    logic [lpl_pkg::GAIN_W-1:0]      target_reg;
    logic [lpl_pkg::HOLD_W-1:0]      peak_hold_reg;
    logic [lpl_pkg::GAIN_W-1:0]      red_hold_reg;
    logic                            out_valid_reg;
    lpl_pkg::out_item_t              out_data_reg;

    logic                            in_accept;
    logic                            out_fire;
    logic                            finish_go;

    logic [lpl_pkg::LEN_W-1:0]       len_eff;
    logic [lpl_pkg::RING_AW-1:0]     pos_now;
    logic [lpl_pkg::LEN_W-1:0]       pos_inc;
    logic [lpl_pkg::RING_AW-1:0]     ring_pos_next;

    lpl_pkg::mac_ctrl_t              mac_ctrl;
    logic signed [lpl_pkg::MAC_A_W-1:0] mac_a;
    logic signed [lpl_pkg::MAC_B_W-1:0] mac_b;
    logic signed [lpl_pkg::ACC_W-1:0]   acc;
    logic [lpl_pkg::ACC_W-1:0]       acc_mag;
    logic [lpl_pkg::ACC_W-1:0]       acc_rnd;
    logic [lpl_pkg::MAG_W-1:0]       acc_q;
    logic [SB-1:0]                   s_mag;
    logic [lpl_pkg::MAG_W-1:0]       peak_now;
    logic                            over;
    logic [lpl_pkg::GAIN_W:0]        rel_q;
    logic [lpl_pkg::GAIN_W-1:0]      gain_rel;
    logic [lpl_pkg::GAIN_W-1:0]      red_now;
    logic signed [SB-1:0]            g_out;

    logic                            div_start;
    logic                            div_done;
    logic [lpl_pkg::QUO_W-1:0]       quotient;

    logic                            ram_we;
    logic [lpl_pkg::RING_AW-1:0]     ram_waddr;
    logic [SB-1:0]                   ram_wdata;
    logic                            ram_re;
    logic [SB-1:0]                   ram_rdata;

    assign in_accept = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    // ring addressing
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_eff = lpl_pkg::LEN_W'(1);
        end
        else if (len_reg > lpl_pkg::LEN_W'(lpl_pkg::MAX_LOOKAHEAD))
        begin
            len_eff = lpl_pkg::LEN_W'(lpl_pkg::MAX_LOOKAHEAD);
        end
        else
        begin
            len_eff = len_reg;
        end
        pos_now       = ({1'b0, ring_pos_reg} < len_eff) ? ring_pos_reg : '0;
        pos_inc       = {1'b0, pos_now} + 1'b1;
        ring_pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[lpl_pkg::RING_AW-1:0];
    end

    // arithmetic around the accumulator
    always_comb
    begin
        s_mag    = sample_reg[SB-1] ? SB'(~sample_reg + 1'b1) : SB'(sample_reg);
        acc_mag  = acc[lpl_pkg::ACC_W-1] ? lpl_pkg::ACC_W'(-acc) : lpl_pkg::ACC_W'(acc);
        acc_rnd  = acc_mag + lpl_pkg::ROUND_HALF;
        acc_q    = acc_rnd[FB +: lpl_pkg::MAG_W];
        peak_now = (acc_q > {1'b0, s_mag}) ? acc_q : {1'b0, s_mag};
        over     = peak_now > lpl_pkg::MAG_W'(ceil_reg);
        rel_q    = acc_rnd[FB +: lpl_pkg::GAIN_W + 1];
        gain_rel = (rel_q > {1'b0, lpl_pkg::UNITY}) ? lpl_pkg::UNITY
                                                   : rel_q[lpl_pkg::GAIN_W-1:0];
        red_now  = lpl_pkg::UNITY - gain_reg;
        // saturate the gained sample to the sample range
        if (sample_reg[SB-1])
        begin
            if (acc_q > lpl_pkg::SMAX + 1'b1)
            begin
                g_out = {1'b1, {(SB-1){1'b0}}};
            end
            else
            begin
                g_out = SB'(~acc_q + 1'b1);
            end
        end
        else
        begin
            g_out = (acc_q > lpl_pkg::SMAX) ? SB'(lpl_pkg::SMAX) : SB'(acc_q);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpl_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = lpl_pkg::ST_IDLE;
                end
            end
            lpl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lpl_pkg::ST_FIR;
                end
            end
            lpl_pkg::ST_FIR:
            begin
                if (k_reg == lpl_pkg::TAP_IW'(lpl_pkg::TAP_COUNT - 1))
                begin
                    state_next = lpl_pkg::ST_PEAK;
                end
            end
            lpl_pkg::ST_PEAK:
            begin
                state_next = over ? lpl_pkg::ST_DIV : lpl_pkg::ST_REL1;
            end
            lpl_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = lpl_pkg::ST_REL1;
                end
            end
            lpl_pkg::ST_REL1:
            begin
                state_next = (target_reg < gain_reg) ? lpl_pkg::ST_GAIN : lpl_pkg::ST_REL2;
            end
            lpl_pkg::ST_REL2:
            begin
                state_next = lpl_pkg::ST_RSUM;
            end
            lpl_pkg::ST_RSUM:
            begin
                state_next = lpl_pkg::ST_GAIN;
            end
            lpl_pkg::ST_GAIN:
            begin
                state_next = lpl_pkg::ST_FINISH;
            end
            lpl_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = lpl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpl_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall     = 1'b1;
        finish_go    = 1'b0;
        mac_ctrl.en  = 1'b0;
        mac_ctrl.clr = 1'b0;
        mac_a        = '0;
        mac_b        = '0;
        div_start    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = g_out;
        ram_re       = 1'b0;
        unique case (state_reg)
            lpl_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            lpl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                ram_re   = in_valid;
            end
            lpl_pkg::ST_FIR:
            begin
                mac_ctrl.en  = 1'b1;
                mac_ctrl.clr = (k_reg == '0);
                mac_a        = lpl_pkg::MAC_A_W'(tap_reg[k_reg]);
                mac_b        = lpl_pkg::MAC_B_W'(lpl_pkg::tap_coef(k_reg));
            end
            lpl_pkg::ST_PEAK:
            begin
                div_start = over;
            end
            lpl_pkg::ST_DIV:
            begin
                div_start = 1'b0;
            end
            lpl_pkg::ST_REL1:
            begin
                mac_ctrl.en  = !(target_reg < gain_reg);
                mac_ctrl.clr = 1'b1;
                mac_a        = lpl_pkg::MAC_A_W'(rel_reg);
                mac_b        = lpl_pkg::MAC_B_W'(gain_reg);
            end
            lpl_pkg::ST_REL2:
            begin
                mac_ctrl.en  = 1'b1;
                mac_a        = lpl_pkg::MAC_A_W'(lpl_pkg::UNITY - lpl_pkg::GAIN_W'(rel_reg));
                mac_b        = lpl_pkg::MAC_B_W'(target_reg);
            end
            lpl_pkg::ST_RSUM:
            begin
                mac_ctrl.en = 1'b0;
            end
            lpl_pkg::ST_GAIN:
            begin
                mac_ctrl.en  = 1'b1;
                mac_ctrl.clr = 1'b1;
                mac_a        = lpl_pkg::MAC_A_W'(s_mag);
                mac_b        = lpl_pkg::MAC_B_W'(gain_reg);
            end
            lpl_pkg::ST_FINISH:
            begin
                finish_go = !out_valid_reg || !out_stall;
                ram_we    = finish_go;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpl_pkg::ST_CLEAR;
            ceil_reg      <= lpl_pkg::CEIL_W'(8388608);
            rel_reg       <= lpl_pkg::COEF_W'(65399);
            len_reg       <= lpl_pkg::LEN_W'(48);
            ring_pos_reg  <= '0;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            gain_reg      <= lpl_pkg::UNITY;
            peak_hold_reg <= '0;
            red_hold_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < lpl_pkg::TAP_COUNT; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == lpl_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            if (in_accept)
            begin
                for (int i = lpl_pkg::TAP_COUNT - 1; i > 0; i--)
                begin
                    tap_reg[i] <= tap_reg[i-1];
                end
                tap_reg[0]   <= in_data.sample_in;
                ring_pos_reg <= ring_pos_next;
                k_reg        <= '0;
                if (in_data.block_start)
                begin
                    peak_hold_reg <= '0;
                    red_hold_reg  <= '0;
                end
            end

            if (state_reg == lpl_pkg::ST_FIR)
            begin
                k_reg <= k_reg + 1'b1;
            end

            if (state_reg == lpl_pkg::ST_PEAK && peak_now > lpl_pkg::MAG_W'(peak_hold_reg))
            begin
                peak_hold_reg <= (peak_now > lpl_pkg::MAG_W'(lpl_pkg::PEAK_MAX))
                                 ? lpl_pkg::PEAK_MAX : peak_now[lpl_pkg::HOLD_W-1:0];
            end

            // instant attack
            if (state_reg == lpl_pkg::ST_REL1 && target_reg < gain_reg)
            begin
                gain_reg <= target_reg;
            end

            if (state_reg == lpl_pkg::ST_RSUM)
            begin
                gain_reg <= gain_rel;
            end

            if (state_reg == lpl_pkg::ST_GAIN && red_now > red_hold_reg)
            begin
                red_hold_reg <= red_now;
            end

            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_en)
            begin
                unique case (lpl_pkg::cfg_reg_t'(cfg_index))
                    lpl_pkg::REG_CEILING:
                    begin
                        ceil_reg <= cfg_data[lpl_pkg::CEIL_W-1:0];
                    end
                    lpl_pkg::REG_RELEASE:
                    begin
                        rel_reg <= cfg_data[lpl_pkg::COEF_W-1:0];
                    end
                    lpl_pkg::REG_LOOKAHEAD:
                    begin
                        len_reg      <= cfg_data[lpl_pkg::LEN_W-1:0];
                        ring_pos_reg <= '0;
                    end
                    default:
                    begin
                        len_reg <= len_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= in_data.sample_in;
            pos_reg    <= pos_now;
        end
        if (state_reg == lpl_pkg::ST_PEAK && !over)
        begin
            target_reg <= lpl_pkg::UNITY;
        end
        if (state_reg == lpl_pkg::ST_DIV && div_done)
        begin
            target_reg <= lpl_pkg::GAIN_W'(quotient);
        end
        if (finish_go)
        begin
            out_data_reg.sample_out     <= ram_rdata;
            out_data_reg.gain_now       <= gain_reg;
            out_data_reg.peak_held      <= peak_hold_reg;
            out_data_reg.reduction_held <= red_hold_reg;
        end
    end

    lpl_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (acc)
    );

    lpl_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend_hi (lpl_pkg::MAG_W'(ceil_reg)),
        .divisor     (peak_now),
        .done        (div_done),
        .quotient    (quotient)
    );

    lpl_ram #(
        .WIDTH (SB),
        .DEPTH (lpl_pkg::MAX_LOOKAHEAD)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pos_now),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[src/lpl_checker.sv]
`default_nettype none
`include "lookahead_peak_limiter_macros.svh"

module lpl_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire lpl_pkg::out_item_t out_data
);

    // a stalled result holds
    `LPL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // one item at a time: busy right after an accept
    `LPL_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // gain never above unity
    `LPL_ASSERT_IMP(a_gain_range, out_valid, out_data.gain_now <= lpl_pkg::UNITY)

    // reduction hold covers the current reduction
    `LPL_ASSERT_IMP(a_red_hold, out_valid, out_data.reduction_held >= lpl_pkg::GAIN_W'(lpl_pkg::UNITY - out_data.gain_now))

endmodule

bind lookahead_peak_limiter lpl_checker u_lpl_checker (.*);

`default_nettype wire
